// ===== design/bitmap_block_allocator_assert.svh =====
// assertion macros for the allocator
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BBA_ASSERT_IMPL(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	(a) |-> (c)) else $error("bba check failed");
`define BBA_ASSERT_NEXT(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	(a) |=> (c)) else $error("bba check failed");
`endif

// ===== design/bba_pkg.sv =====
package bba_pkg;
	localparam int POOL_CELLS = 32;
	localparam int TABLE_ENTRIES = 32;
	localparam int CW = $clog2(POOL_CELLS);
	localparam int EW = $clog2(TABLE_ENTRIES);
	localparam int LW = $clog2(POOL_CELLS + 1);
	localparam int UW = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [1:0] {CMD_FIRST = 2'd0, CMD_NEXT = 2'd1, CMD_FREE = 2'd2,
		CMD_ALIAS = 2'd3} cmd_t;
	typedef enum logic [1:0] {ST_OK = 2'd0, ST_NOSPACE = 2'd1, ST_FULL = 2'd2,
		ST_NOID = 2'd3} status_t;

	typedef struct packed {
		logic [1:0] command;
		logic [15:0] block_id;
		logic [5:0] block_size;
		logic [15:0] other_id;
	} cmd_item_t;

	typedef struct packed {
		logic [4:0] start_address;
		logic [1:0] status;
	} result_t;

	// one table entry as stored in memory
	typedef struct packed {
		logic [15:0] id;
		logic [CW-1:0] start;
		logic [LW-1:0] len;
	} entry_t;
endpackage

// ===== design/bba_table_ram.sv =====
// allocation table memory, one write and one registered read port
module bba_table_ram (
	input logic clk,
	input logic we,
	input logic [bba_pkg::EW-1:0] waddr,
	input bba_pkg::entry_t wdata,
	input logic [bba_pkg::EW-1:0] raddr,
	output bba_pkg::entry_t rdata
);
	bba_pkg::entry_t mem [bba_pkg::TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== design/bitmap_block_allocator.sv =====
// one transaction at a time; busy from the accepting edge until done, next start taken with done
// rejects by id, table count or size go straight to the done state, which strobes done
// first-fit: bitmap scan up to the first fitting run, then the cells are marked and the entry recorded
// next-fit: full bitmap walk, then cells are marked from just past the highest set cell found
// free: every table entry is read and checked, and the cells of each matching entry are cleared;
// alias adds a lookup sweep before that; reset clears the bitmap and entry count; done never stalls
`include "bitmap_block_allocator_assert.svh"
module bitmap_block_allocator (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input bba_pkg::cmd_item_t cmd,
	output logic done,
	output bba_pkg::result_t result
);
	localparam int CW = bba_pkg::CW;
	localparam int EW = bba_pkg::EW;
	localparam int LW = bba_pkg::LW;
	localparam int UW = bba_pkg::UW;
	localparam int NC = bba_pkg::POOL_CELLS;
	localparam int NE = bba_pkg::TABLE_ENTRIES;

	typedef enum logic [3:0] {S_IDLE, S_SCAN, S_MARK, S_FSRD, S_FSCHK, S_CLR,
		S_ARD, S_ACHK, S_AWR, S_DONE} state_t;

	state_t state_q;
	bba_pkg::cmd_item_t c_q;
	logic [NC-1:0] map_q;
	logic [UW-1:0] used_q;
	logic [LW:0] idx_q;      // cell or entry index, wide enough for the end
	logic [LW:0] run_q;
	logic [CW-1:0] pos_q;
	logic [LW-1:0] cnt_q;
	logic [CW:0] hi_q;
	logic [1:0] st_q;
	logic [CW-1:0] rs_q;
	logic fa_q, fg_q;
	logic [EW-1:0] ea_q;
	logic [CW-1:0] gs_q;
	logic [LW-1:0] gl_q;

	logic we;
	logic [EW-1:0] waddr, raddr;
	bba_pkg::entry_t wdata, rd;
	logic rvalid; // entry below fill count
	logic [EW-1:0] rd_idx_q;

	bba_table_ram u_ram (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rd));

	assign busy = (state_q != S_IDLE);
	assign raddr = idx_q[EW-1:0];
	assign rvalid = ({1'b0, rd_idx_q} < (EW+1)'(used_q));

	logic [15:0] rid;
	assign rid = rvalid ? rd.id : 16'd0;

	logic [LW:0] sz;
	assign sz = (LW+1)'(c_q.block_size);

	// memory write port
	always_comb begin
		we = 1'b0;
		waddr = used_q[EW-1:0];
		wdata = '{id: c_q.block_id, start: pos_q, len: sz[LW-1:0]};
		if (state_q == S_MARK && cnt_q == sz[LW-1:0]) begin
			we = 1'b1;
		end else if (state_q == S_FSCHK && rid == c_q.block_id && rid != 16'd0) begin
			we = 1'b1;
			waddr = rd_idx_q;
			wdata = '{id: 16'd0, start: rd.start, len: rd.len};
		end else if (state_q == S_AWR) begin
			we = 1'b1;
			waddr = ea_q;
			wdata = '{id: c_q.block_id, start: gs_q, len: gl_q};
		end
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			map_q <= '0;
			used_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						c_q <= cmd;
						idx_q <= '0;
						run_q <= '0;
						hi_q <= '0;
						rs_q <= '0;
						fa_q <= 1'b0;
						fg_q <= 1'b0;
						if (cmd.block_id == 16'd0) begin
							st_q <= bba_pkg::ST_NOID;
							state_q <= S_DONE;
						end else if (cmd.command == bba_pkg::CMD_FIRST
							|| cmd.command == bba_pkg::CMD_NEXT) begin
							if (used_q >= UW'(NE)) begin
								st_q <= bba_pkg::ST_FULL;
								state_q <= S_DONE;
							end else if (cmd.block_size == 6'd0
								|| 32'(cmd.block_size) > NC) begin
								st_q <= bba_pkg::ST_NOSPACE;
								state_q <= S_DONE;
							end else begin
								st_q <= bba_pkg::ST_NOSPACE;
								state_q <= S_SCAN;
							end
						end else if (cmd.command == bba_pkg::CMD_FREE) begin
							st_q <= bba_pkg::ST_NOID;
							state_q <= S_FSRD;
						end else begin
							if (cmd.other_id == 16'd0) begin
								st_q <= bba_pkg::ST_NOID;
								state_q <= S_DONE;
							end else begin
								state_q <= S_ARD;
							end
						end
					end
				end
				// bitmap walk, one cell a cycle
				S_SCAN: begin
					if (idx_q == (LW+1)'(NC)) begin
						if (c_q.command == bba_pkg::CMD_NEXT
							&& (32'(hi_q) + 32'(c_q.block_size) <= NC)) begin
							pos_q <= hi_q[CW-1:0];
							cnt_q <= '0;
							state_q <= S_MARK;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						if (map_q[idx_q[CW-1:0]]) begin
							run_q <= '0;
							hi_q <= (CW+1)'(idx_q) + (CW+1)'(1);
						end else begin
							run_q <= run_q + (LW+1)'(1);
							if (c_q.command == bba_pkg::CMD_FIRST
								&& run_q + (LW+1)'(1) == sz) begin
								pos_q <= CW'(idx_q + (LW+1)'(1) - sz);
								cnt_q <= '0;
								state_q <= S_MARK;
							end
						end
						idx_q <= idx_q + (LW+1)'(1);
					end
				end
				// set cells one by one, then record entry
				S_MARK: begin
					if (cnt_q == sz[LW-1:0]) begin
						used_q <= used_q + UW'(1);
						st_q <= bba_pkg::ST_OK;
						rs_q <= pos_q;
						state_q <= S_DONE;
					end else begin
						map_q[pos_q + CW'(cnt_q)] <= 1'b1;
						cnt_q <= cnt_q + LW'(1);
					end
				end
				// free sweep: read entry
				S_FSRD: begin
					if (idx_q == (LW+1)'(NE)) begin
						state_q <= (c_q.command == bba_pkg::CMD_ALIAS) ? S_AWR : S_DONE;
					end else begin
						rd_idx_q <= idx_q[EW-1:0];
						idx_q <= idx_q + (LW+1)'(1);
						state_q <= S_FSCHK;
					end
				end
				S_FSCHK: begin
					if (rid == c_q.block_id) begin
						if (c_q.command == bba_pkg::CMD_FREE) st_q <= bba_pkg::ST_OK;
						pos_q <= rd.start;
						cnt_q <= '0;
						run_q <= (LW+1)'(rd.len);
						state_q <= S_CLR;
					end else begin
						state_q <= S_FSRD;
					end
				end
				// clear cells of one entry, clipped at pool end
				S_CLR: begin
					if ((LW+1)'(cnt_q) == run_q
						|| 32'(pos_q) + 32'(cnt_q) >= NC) begin
						state_q <= S_FSRD;
					end else begin
						map_q[pos_q + CW'(cnt_q)] <= 1'b0;
						cnt_q <= cnt_q + LW'(1);
					end
				end
				// alias lookup sweep for lowest block_id and other_id entries
				S_ARD: begin
					if (idx_q == (LW+1)'(NE)) begin
						state_q <= S_DONE;
						st_q <= bba_pkg::ST_NOID;
					end else begin
						rd_idx_q <= idx_q[EW-1:0];
						idx_q <= idx_q + (LW+1)'(1);
						state_q <= S_ACHK;
					end
				end
				S_ACHK: begin
					logic fa, fg;
					fa = fa_q || (rid == c_q.block_id);
					fg = fg_q || (rid == c_q.other_id);
					if (!fa_q && rid == c_q.block_id) begin
						ea_q <= rd_idx_q;
						rs_q <= rd.start;
					end
					if (!fg_q && rid == c_q.other_id) begin
						gs_q <= rd.start;
						gl_q <= rd.len;
					end
					fa_q <= fa;
					fg_q <= fg;
					if (fa && fg) begin
						st_q <= bba_pkg::ST_OK;
						if (c_q.block_id == c_q.other_id) begin
							state_q <= S_DONE;
						end else begin
							idx_q <= '0;
							state_q <= S_FSRD;
						end
					end else begin
						state_q <= S_ARD;
					end
				end
				S_AWR: begin
					rs_q <= gs_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					done <= 1'b1;
					result.status <= st_q;
					result.start_address <= (st_q == bba_pkg::ST_OK) ? rs_q : '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`BBA_ASSERT_NEXT(a_done_pulse, done, !done)
	`BBA_ASSERT_IMPL(a_used_bound, 1'b1, used_q <= UW'(NE))
	`BBA_ASSERT_NEXT(a_start_busy, start && !busy, busy)
endmodule
